// ===== src/sbfd_pkg.sv =====
`default_nettype none

package sbfd_pkg;

   localparam int FRAME_BYTES   = 25;
   localparam int NUM_CHANNELS  = 16;
   localparam int CHAN_BITS     = 11;
   localparam int PAYLOAD_BYTES = 22;
   localparam int STREAM_BITS   = NUM_CHANNELS * CHAN_BITS;
   localparam int FILL_BITS     = $clog2(FRAME_BYTES + 1);
   localparam int INDEX_BITS    = $clog2(NUM_CHANNELS);

   localparam logic [FILL_BITS-1:0] FILL_COMPLETE = FILL_BITS'(FRAME_BYTES - 1);

   localparam logic [15:0] GAP_LIMIT_RESET = 16'd2500;
   localparam logic [7:0]  HEADER_RESET    = 8'h0F;
   localparam logic [7:0]  END_BYTE_ZERO   = 8'h00;
   localparam int          FLAG_LOST_BIT   = 3;

   localparam logic [7:0] END_MARKS [4] = '{8'h04, 8'h14, 8'h24, 8'h34};

   localparam int          CSR_ADDR_BITS = 3;
   localparam logic        REG_GAP_LIMIT = 1'b0;
   localparam logic        REG_HEADER    = 1'b1;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [31:0] time_us;
   } req_item_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] channel_index;
      logic [CHAN_BITS-1:0]  channel_value;
      logic [7:0]            flags_byte;
      logic                  frame_counted;
      logic                  last;
   } rsp_item_type;

   typedef struct packed {
      logic                   valid;
      logic [7:0]             flags;
      logic [STREAM_BITS-1:0] stream;
   } frame_load_type;

endpackage

`default_nettype wire

// ===== src/sbfd_byte_cell.sv =====
`default_nettype none

module sbfd_byte_cell (
   input  wire logic       clock,
   input  wire logic       shift,
   input  wire logic [7:0] shift_in,
   output logic      [7:0] value
);

   logic [7:0] value_ff;
   logic [7:0] value_in;

   always_comb begin
      value_in = shift ? shift_in : value_ff;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ===== src/sbfd_chan_cell.sv =====
`default_nettype none

module sbfd_chan_cell (
   input  wire logic                          clock,
   input  wire logic                          load,
   input  wire logic [sbfd_pkg::CHAN_BITS-1:0] load_value,
   input  wire logic                          shift,
   input  wire logic [sbfd_pkg::CHAN_BITS-1:0] shift_in,
   output logic      [sbfd_pkg::CHAN_BITS-1:0] value
);

   import sbfd_pkg::*;

   logic [CHAN_BITS-1:0] value_ff;
   logic [CHAN_BITS-1:0] value_in;

   always_comb begin
      if (load) begin
         value_in = load_value;
      end else if (shift) begin
         value_in = shift_in;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ===== src/sbfd_unpacker.sv =====
`default_nettype none

module sbfd_unpacker (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sbfd_pkg::frame_load_type frame_load,
   input  wire logic                     rsp_stall,
   output logic                          rsp_valid,
   output sbfd_pkg::rsp_item_type        rsp_item
);

   import sbfd_pkg::*;

   logic                  busy_ff;
   logic                  busy_in;
   logic [INDEX_BITS-1:0] index_ff;
   logic [INDEX_BITS-1:0] index_in;
   logic [7:0]            flags_ff;
   logic [7:0]            flags_in;
   logic                  take;
   logic                  last_chan;

   logic [CHAN_BITS-1:0] lane_value [NUM_CHANNELS];

   assign take      = busy_ff && !rsp_stall;
   assign last_chan = (index_ff == INDEX_BITS'(NUM_CHANNELS - 1));

   genvar k;
   generate
      for (k = 0; k < NUM_CHANNELS; k++) begin : g_lane
         logic [CHAN_BITS-1:0] next_value;
         if (k == NUM_CHANNELS - 1) begin : g_tail
            assign next_value = '0;
         end else begin : g_mid
            assign next_value = lane_value[k+1];
         end
         sbfd_chan_cell u_cell (
            .clock      (clock),
            .load       (frame_load.valid),
            .load_value (frame_load.stream[k*CHAN_BITS +: CHAN_BITS]),
            .shift      (take),
            .shift_in   (next_value),
            .value      (lane_value[k])
         );
      end
   endgenerate

   always_comb begin
      busy_in  = busy_ff;
      index_in = index_ff;
      flags_in = flags_ff;
      if (frame_load.valid) begin
         busy_in  = 1'b1;
         index_in = '0;
         flags_in = frame_load.flags;
      end else if (take) begin
         index_in = index_ff + 1'b1;
         if (last_chan) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         index_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         index_ff <= index_in;
      end
      flags_ff <= flags_in;
   end

   always_comb begin
      rsp_valid              = busy_ff;
      rsp_item.channel_index = index_ff;
      rsp_item.channel_value = lane_value[0];
      rsp_item.flags_byte    = flags_ff;
      rsp_item.frame_counted = ~flags_ff[FLAG_LOST_BIT];
      rsp_item.last          = last_chan;
   end

endmodule

`default_nettype wire

// ===== src/sbus_frame_decoder_top.sv =====
// Serial bus frame decoder. One received byte with its microsecond timestamp is taken per item,
// and a new item can be taken every cycle while req_stall is low. A gap above gap_limit_us
// restarts the frame fill. The byte window is a chain of 25 byte cells that shifts once per
// item, so the frame check is done in the same cycle the 25th byte arrives. A frame that
// passes loads a chain of sixteen channel cells and yields sixteen result items, one per cycle
// while rsp_stall is low, channel 0 first and last set on channel 15. req_stall is raised only
// while results of the previous frame are still pending and the window already holds 24
// bytes, since the next byte could complete a new frame. There is no clearing pass after reset.
`default_nettype none

module sbus_frame_decoder_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire sbfd_pkg::req_item_type               req_item,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output sbfd_pkg::rsp_item_type                    rsp_item,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [sbfd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [31:0]                          csr_pwdata,
   output logic      [31:0]                          csr_prdata,
   output logic                                      csr_pready
);

   import sbfd_pkg::*;

   logic [15:0]          gap_limit_ff;
   logic [15:0]          gap_limit_in;
   logic [7:0]           header_ff;
   logic [7:0]           header_in;
   logic [FILL_BITS-1:0] fill_ff;
   logic [FILL_BITS-1:0] fill_in;
   logic [31:0]          prev_time_ff;
   logic [31:0]          prev_time_in;
   logic [1:0]           end_index_ff;
   logic [1:0]           end_index_in;

   logic                 req_take;
   logic                 csr_write;
   logic [31:0]          gap;
   logic                 restart;
   logic [FILL_BITS-1:0] fill_eff;
   logic                 complete;
   logic                 frame_match;
   frame_load_type       frame_load;

   logic [7:0] cell_value [FRAME_BYTES];

   assign req_stall = rsp_valid && (fill_ff == FILL_COMPLETE);
   assign req_take  = req_valid && !req_stall;

   genvar i;
   generate
      for (i = 0; i < FRAME_BYTES; i++) begin : g_window
         logic [7:0] next_byte;
         if (i == FRAME_BYTES - 1) begin : g_tail
            assign next_byte = req_item.data_byte;
         end else begin : g_mid
            assign next_byte = cell_value[i+1];
         end
         sbfd_byte_cell u_cell (
            .clock    (clock),
            .shift    (req_take),
            .shift_in (next_byte),
            .value    (cell_value[i])
         );
      end
      for (i = 0; i < PAYLOAD_BYTES; i++) begin : g_stream
         assign frame_load.stream[i*8 +: 8] = cell_value[i+2];
      end
   endgenerate

   always_comb begin
      gap         = req_item.time_us - prev_time_ff;
      restart     = gap > {16'b0, gap_limit_ff};
      fill_eff    = restart ? '0 : fill_ff;
      complete    = (fill_eff == FILL_COMPLETE);
      frame_match = complete && (cell_value[1] == header_ff) &&
                    ((req_item.data_byte == END_BYTE_ZERO) ||
                     (req_item.data_byte == END_MARKS[end_index_ff]));
   end

   assign frame_load.valid = req_take && frame_match;
   assign frame_load.flags = cell_value[FRAME_BYTES-1];

   always_comb begin
      fill_in      = fill_ff;
      prev_time_in = prev_time_ff;
      end_index_in = end_index_ff;
      if (req_take) begin
         prev_time_in = req_item.time_us;
         if (frame_match) begin
            fill_in      = '0;
            end_index_in = end_index_ff + 1'b1;
         end else if (complete) begin
            fill_in = FILL_COMPLETE;
         end else begin
            fill_in = fill_eff + 1'b1;
         end
      end
   end

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      gap_limit_in = gap_limit_ff;
      header_in    = header_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_GAP_LIMIT: gap_limit_in = csr_pwdata[15:0];
            REG_HEADER:    header_in    = csr_pwdata[7:0];
            default:       gap_limit_in = gap_limit_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_GAP_LIMIT: csr_prdata = {16'b0, gap_limit_ff};
         REG_HEADER:    csr_prdata = {24'b0, header_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff <= GAP_LIMIT_RESET;
         header_ff    <= HEADER_RESET;
         fill_ff      <= '0;
         prev_time_ff <= '0;
         end_index_ff <= '0;
      end else begin
         gap_limit_ff <= gap_limit_in;
         header_ff    <= header_in;
         fill_ff      <= fill_in;
         prev_time_ff <= prev_time_in;
         end_index_ff <= end_index_in;
      end
   end

   sbfd_unpacker u_unpacker (
      .clock      (clock),
      .reset      (reset),
      .frame_load (frame_load),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_COMPLETE)
      else $error("Window fill count exceeds the frame length.");

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      frame_load.valid |-> !rsp_valid)
      else $error("A frame was matched while results were still pending.");

   a_match_starts_output: assert property (@(posedge clock) disable iff (reset)
      frame_load.valid |=> (rsp_valid && (rsp_item.channel_index == '0) && (fill_ff == '0)))
      else $error("A matched frame did not start its result items.");

   a_end_index_steps: assert property (@(posedge clock) disable iff (reset)
      !frame_load.valid |=> $stable(end_index_ff))
      else $error("End byte index moved without a matched frame.");

endmodule

`default_nettype wire
